/* design/metc_pkg.sv */
// shared constants, types and codes of the mandelbrot escape-time color unit
`default_nettype none

package metc_pkg;

    // fixed-point format and widths
    localparam int FRAC_BITS = 28;
    localparam int ITER_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int COLOR_W   = 8;
    localparam int CFG_W     = 16;

    // iteration limit after reset
    localparam logic [CFG_W-1:0] MAX_ITER_RESET = 16'd10000;

    // squared magnitude bound, 4.0 in the truncated square format
    localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'd4 << FRAC_BITS;

    // color codes
    localparam logic [COLOR_W-1:0] COLOR_INSIDE = 8'd255;
    localparam logic [COLOR_W-1:0] MOD_LAST     = 8'd254;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD
    } metc_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic res_wr;
        logic res_inside;
    } metc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic lim_zero;
        logic escaped;
        logic at_limit;
    } metc_sts_t;

endpackage

`default_nettype wire

/* design/metc_ifs.sv */
// valid/ready channel interfaces for points, colors and configuration writes
`default_nettype none

// point channel
interface metc_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [metc_pkg::COORD_W-1:0]  c_real;
    logic signed [metc_pkg::COORD_W-1:0]  c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

// color result channel
interface metc_color_if;
    logic                          valid;
    logic                          ready;
    logic [metc_pkg::COLOR_W-1:0]  color_index;

    modport source (output valid, output color_index, input ready);
    modport sink   (input valid, input color_index, output ready);
endinterface

// iteration limit write channel
interface metc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [metc_pkg::CFG_W-1:0]  max_iterations;

    modport source (output valid, output max_iterations, input ready);
    modport sink   (input valid, input max_iterations, output ready);
endinterface

`default_nettype wire

/* design/metc_dp.sv */
// datapath: z registers, square/cross products, escape test, counters, color register
`default_nettype none

module metc_dp
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic signed [metc_pkg::COORD_W-1:0] c_real,
    input  wire logic signed [metc_pkg::COORD_W-1:0] c_imag,
    input  wire logic                                cfg_wr,
    input  wire logic [metc_pkg::CFG_W-1:0]          cfg_data,
    input  wire metc_pkg::metc_cmd_t                 cmd,
    output metc_pkg::metc_sts_t                      sts,
    output logic [metc_pkg::COLOR_W-1:0]             color_index
);

    logic [metc_pkg::CFG_W-1:0]            max_iter_reg;
    logic signed [metc_pkg::COORD_W-1:0]   a_reg;
    logic signed [metc_pkg::COORD_W-1:0]   b_reg;
    logic signed [metc_pkg::COORD_W-1:0]   x_reg;
    logic signed [metc_pkg::COORD_W-1:0]   x_next;
    logic signed [metc_pkg::COORD_W-1:0]   y_reg;
    logic signed [metc_pkg::COORD_W-1:0]   y_next;
    logic signed [metc_pkg::PROD_W-1:0]    xx_reg;
    logic signed [metc_pkg::PROD_W-1:0]    yy_reg;
    logic signed [metc_pkg::PROD_W-1:0]    xy_reg;
    logic [metc_pkg::ITER_BITS-1:0]        iter_reg;
    logic [metc_pkg::ITER_BITS-1:0]        iter_next;
    logic [metc_pkg::COLOR_W-1:0]          mod_reg;
    logic [metc_pkg::COLOR_W-1:0]          mod_next;
    logic [metc_pkg::COLOR_W-1:0]          color_reg;
    logic [metc_pkg::COLOR_W-1:0]          color_next;

    logic [metc_pkg::ITER_BITS-1:0]        lim;
    logic [metc_pkg::ITER_BITS:0]          iter_inc;
    logic [metc_pkg::PROD_W-1:0]           x2;
    logic [metc_pkg::PROD_W-1:0]           y2;
    logic [metc_pkg::PROD_W-1:0]           mag2;
    logic [metc_pkg::PROD_W-1:0]           xy2;
    logic signed [metc_pkg::PROD_W-1:0]    xy2_sh;

    // iteration limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= metc_pkg::MAX_ITER_RESET;
        end
        else if (cfg_wr)
        begin
            max_iter_reg <= cfg_data;
        end
    end

    assign lim = metc_pkg::ITER_BITS'(max_iter_reg);

    // truncated squares, escape test and next z
    always_comb
    begin
        x2       = $unsigned(xx_reg) >> metc_pkg::FRAC_BITS;
        y2       = $unsigned(yy_reg) >> metc_pkg::FRAC_BITS;
        mag2     = x2 + y2;
        xy2      = {xy_reg[metc_pkg::PROD_W-2:0], 1'b0};
        xy2_sh   = $signed(xy2) >>> metc_pkg::FRAC_BITS;
        x_next   = $signed(x2[metc_pkg::COORD_W-1:0] - y2[metc_pkg::COORD_W-1:0]
                           + $unsigned(a_reg));
        y_next   = $signed(xy2_sh[metc_pkg::COORD_W-1:0] + $unsigned(b_reg));
        iter_inc = {1'b0, iter_reg} + {{metc_pkg::ITER_BITS{1'b0}}, 1'b1};
        iter_next = iter_inc[metc_pkg::ITER_BITS-1:0];
        mod_next  = (mod_reg == metc_pkg::MOD_LAST) ? '0 : mod_reg + 8'd1;
        color_next = cmd.res_inside ? metc_pkg::COLOR_INSIDE : mod_reg;
    end

    // status to the controller
    assign sts.lim_zero = (lim == '0);
    assign sts.escaped  = (mag2 > metc_pkg::ESCAPE_LIMIT);
    assign sts.at_limit = (iter_inc == {1'b0, lim});

    // point, z, product and counter registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= c_real;
            b_reg    <= c_imag;
            x_reg    <= '0;
            y_reg    <= '0;
            iter_reg <= '0;
            mod_reg  <= '0;
        end
        else if (cmd.step)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            iter_reg <= iter_next;
            mod_reg  <= mod_next;
        end

        if (cmd.mul)
        begin
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            xy_reg <= x_reg * y_reg;
        end

        if (cmd.res_wr)
        begin
            color_reg <= color_next;
        end
    end

    assign color_index = color_reg;

endmodule

`default_nettype wire

/* design/metc_ctrl.sv */
// controller: iteration sequencing and result register handshake
`default_nettype none

module metc_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire metc_pkg::metc_sts_t sts,
    output metc_pkg::metc_cmd_t      cmd
);

    metc_pkg::metc_state_t state_reg;
    metc_pkg::metc_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_free;

    // state and result valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= metc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            metc_pkg::ST_IDLE:
            begin
                // zero limit finishes on the accepting transfer
                in_ready = sts.lim_zero ? out_free : 1'b1;
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    if (sts.lim_zero)
                    begin
                        cmd.res_wr     = 1'b1;
                        cmd.res_inside = 1'b1;
                    end
                    else
                    begin
                        state_next = metc_pkg::ST_MUL;
                    end
                end
            end
            metc_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = metc_pkg::ST_UPD;
            end
            metc_pkg::ST_UPD:
            begin
                // finish waits here while the result register is still full
                if (sts.escaped || sts.at_limit)
                begin
                    if (out_free)
                    begin
                        cmd.res_wr     = 1'b1;
                        cmd.res_inside = !sts.escaped;
                        state_next     = metc_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = metc_pkg::ST_MUL;
                end
            end
            default:
            begin
                state_next = metc_pkg::ST_IDLE;
            end
        endcase
    end

    // result valid: set on write, cleared on output transfer
    always_comb
    begin
        priority if (cmd.res_wr)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* design/mandelbrot_escape_time_color_unit.sv */
// top level of the mandelbrot escape-time color unit
// one point at a time; each iteration runs a registered 32x32 multiplier stage (ST_MUL),
// then the square-sum compare and z update adders (ST_UPD)
// with a zero limit the result is written at the transfer edge; the next point is taken
// in the idle state after the last iteration; a finish stalls while the output is still full
// a done color waits in the output register
// reset clears the controller and output valid and loads an iteration limit of 10000
`default_nettype none

module mandelbrot_escape_time_color_unit
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    metc_point_if.sink          point,
    metc_color_if.source        result,
    metc_cfg_if.sink            cfg
);

    metc_pkg::metc_cmd_t cmd;
    metc_pkg::metc_sts_t sts;
    logic                cfg_wr;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    // controller
    metc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath
    metc_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .c_real      (point.c_real),
        .c_imag      (point.c_imag),
        .cfg_wr      (cfg_wr),
        .cfg_data    (cfg.max_iterations),
        .cmd         (cmd),
        .sts         (sts),
        .color_index (result.color_index)
    );

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_wr |-> (!result.valid || result.ready))
        else $error("result register overwritten");

    // a nonzero-limit transfer starts with a multiply
    a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (point.valid && point.ready && !sts.lim_zero) |=> cmd.mul)
        else $error("no multiply after point transfer");

    // every non-final update is followed by a multiply
    a_step_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> cmd.mul)
        else $error("no multiply after update");

    // reaching the limit unescaped, or a zero limit, gives the inside color
    a_inside_color: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_wr && cmd.res_inside) |=>
            (result.valid && result.color_index == metc_pkg::COLOR_INSIDE))
        else $error("inside color wrong");

endmodule

`default_nettype wire
